FILE: sv/bbc_pkg.sv
`timescale 1ns / 1ps

package bbc_pkg;

    localparam int NUM_SLOTS_DEF  = 256;
    localparam int BLOCK_BITS_DEF = 32;
    localparam int BLOCK_NUM_W    = 32;
    localparam int SLOT_FIELD_W   = 8;

    typedef enum logic
    {
        ACT_GET,
        ACT_FLAGS
    } bbc_action_t;

    typedef struct packed
    {
        logic touched;
        logic uptodate;
        logic dirty;
    } bbc_flags_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_SEARCH,
        ST_HIT_CHK,
        ST_FILL_FREE,
        ST_EVICT,
        ST_UNLINK,
        ST_APPEND,
        ST_FLAG_RD,
        ST_FLAG_WR,
        ST_DONE
    } bbc_state_t;

endpackage

FILE: sv/bbc_if.sv
`timescale 1ns / 1ps

interface bbc_req_if;
    import bbc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    action;
    logic [BLOCK_NUM_W-1:0]  block_number;
    logic [SLOT_FIELD_W-1:0] flag_slot;
    logic                    new_dirty;
    logic                    new_uptodate;

    modport source
    (
        output valid, action, block_number, flag_slot, new_dirty, new_uptodate,
        input  ready
    );

    modport sink
    (
        input  valid, action, block_number, flag_slot, new_dirty, new_uptodate,
        output ready
    );
endinterface

interface bbc_rsp_if;
    import bbc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [SLOT_FIELD_W-1:0] slot;
    logic                    hit;
    logic                    from_free;
    logic                    evicted_valid;
    logic [BLOCK_NUM_W-1:0]  evicted_block;
    logic                    evicted_dirty;

    modport source
    (
        output valid, slot, hit, from_free, evicted_valid, evicted_block, evicted_dirty,
        input  ready
    );

    modport sink
    (
        input  valid, slot, hit, from_free, evicted_valid, evicted_block, evicted_dirty,
        output ready
    );
endinterface

FILE: sv/bbc_ram.sv
`timescale 1ns / 1ps

module bbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: sv/block_buffer_cache_lru.sv
`timescale 1ns / 1ps

// Channel  Dir  Carries                                              Accepted when
// req      in   action, block_number, flag_slot, new_dirty/uptodate  req.valid & req.ready
// rsp      out  slot, hit, from_free, evicted_valid/block/dirty      rsp.valid & rsp.ready
//
// A lookup scans the used slots (used = slots filled so far, at most NUM_SLOTS) until a hit:
// one stored tag is read from the tag RAM and compared per cycle by a single comparator.
// A flag write reads the flag RAM and then writes it. req.ready is high only between items.
// Reset empties the cache at once; the tag, flag and link RAMs are not cleared.
// A result waits in the output register while rsp.ready is low; the next item is still taken
// and holds in its last cycle until that register frees.

module block_buffer_cache_lru #(
    parameter int NUM_SLOTS  = bbc_pkg::NUM_SLOTS_DEF,
    parameter int BLOCK_BITS = bbc_pkg::BLOCK_BITS_DEF
) (
    input logic        clk,
    input logic        rst_n,
    bbc_req_if.sink    req,
    bbc_rsp_if.source  rsp
);
    import bbc_pkg::*;

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam int TAG_W  = (BLOCK_BITS < BLOCK_NUM_W) ? BLOCK_BITS : BLOCK_NUM_W;
    localparam int FLG_W  = $bits(bbc_flags_t);

    bbc_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  free_reg, free_next;
    logic [SLOT_W-1:0] head_reg, head_next;
    logic [SLOT_W-1:0] tail_reg, tail_next;
    logic              rsp_valid_reg, rsp_valid_next;

    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic                    act_reg, act_next;
    logic [TAG_W-1:0]        tag_reg, tag_next;
    logic [SLOT_FIELD_W-1:0] fslot_reg, fslot_next;
    logic                    fdirty_reg, fdirty_next;
    logic                    fupd_reg, fupd_next;
    logic                    hit_reg, hit_next;
    logic                    ffree_reg, ffree_next;
    logic                    evict_reg, evict_next;
    logic [TAG_W-1:0]        ev_tag_reg, ev_tag_next;
    logic                    ev_dirty_reg, ev_dirty_next;

    logic [SLOT_FIELD_W-1:0] rsp_slot_reg, rsp_slot_next;
    logic                    rsp_hit_reg, rsp_hit_next;
    logic                    rsp_free_reg, rsp_free_next;
    logic                    rsp_ev_reg, rsp_ev_next;
    logic [BLOCK_NUM_W-1:0]  rsp_ev_blk_reg, rsp_ev_blk_next;
    logic                    rsp_ev_dirty_reg, rsp_ev_dirty_next;

    logic              tag_we, tag_re;
    logic [SLOT_W-1:0] tag_waddr, tag_raddr;
    logic [TAG_W-1:0]  tag_wdata, tag_rdata;

    logic              flg_we, flg_re;
    logic [SLOT_W-1:0] flg_waddr, flg_raddr;
    bbc_flags_t        flg_wdata, flg_rdata;

    logic              nxt_we, nxt_re;
    logic [SLOT_W-1:0] nxt_waddr, nxt_raddr, nxt_wdata, nxt_rdata;
    logic              prv_we, prv_re;
    logic [SLOT_W-1:0] prv_waddr, prv_raddr, prv_wdata, prv_rdata;

    logic [CNT_W-1:0]  used;
    logic              cache_empty;
    logic              cache_full;
    logic              scan_last;
    logic              tag_match;
    logic              fslot_ok;
    logic [SLOT_W-1:0] fslot_idx;
    logic [SLOT_W-1:0] free_slot;

    bbc_ram #(.WIDTH(TAG_W), .DEPTH(NUM_SLOTS)) u_tag_ram
    (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .re    (tag_re),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

    bbc_ram #(.WIDTH(FLG_W), .DEPTH(NUM_SLOTS)) u_flag_ram
    (
        .clk   (clk),
        .we    (flg_we),
        .waddr (flg_waddr),
        .wdata (flg_wdata),
        .re    (flg_re),
        .raddr (flg_raddr),
        .rdata (flg_rdata)
    );

    bbc_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_SLOTS)) u_next_ram
    (
        .clk   (clk),
        .we    (nxt_we),
        .waddr (nxt_waddr),
        .wdata (nxt_wdata),
        .re    (nxt_re),
        .raddr (nxt_raddr),
        .rdata (nxt_rdata)
    );

    bbc_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_SLOTS)) u_prev_ram
    (
        .clk   (clk),
        .we    (prv_we),
        .waddr (prv_waddr),
        .wdata (prv_wdata),
        .re    (prv_re),
        .raddr (prv_raddr),
        .rdata (prv_rdata)
    );

    assign used        = CNT_W'(NUM_SLOTS) - free_reg;
    assign cache_empty = (free_reg == CNT_W'(NUM_SLOTS));
    assign cache_full  = (free_reg == '0);
    assign scan_last   = ((CNT_W'(slot_reg) + CNT_W'(1)) == used);
    assign tag_match   = (tag_rdata == tag_reg);
    assign fslot_ok    = (32'(fslot_reg) < 32'(NUM_SLOTS));
    assign fslot_idx   = SLOT_W'(fslot_reg);
    assign free_slot   = SLOT_W'(used);

    assign req.ready         = (state_reg == ST_IDLE);
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.slot          = rsp_slot_reg;
    assign rsp.hit           = rsp_hit_reg;
    assign rsp.from_free     = rsp_free_reg;
    assign rsp.evicted_valid = rsp_ev_reg;
    assign rsp.evicted_block = rsp_ev_blk_reg;
    assign rsp.evicted_dirty = rsp_ev_dirty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            free_reg      <= CNT_W'(NUM_SLOTS);
            head_reg      <= '0;
            tail_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_reg      <= free_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg         <= slot_next;
        act_reg          <= act_next;
        tag_reg          <= tag_next;
        fslot_reg        <= fslot_next;
        fdirty_reg       <= fdirty_next;
        fupd_reg         <= fupd_next;
        hit_reg          <= hit_next;
        ffree_reg        <= ffree_next;
        evict_reg        <= evict_next;
        ev_tag_reg       <= ev_tag_next;
        ev_dirty_reg     <= ev_dirty_next;
        rsp_slot_reg     <= rsp_slot_next;
        rsp_hit_reg      <= rsp_hit_next;
        rsp_free_reg     <= rsp_free_next;
        rsp_ev_reg       <= rsp_ev_next;
        rsp_ev_blk_reg   <= rsp_ev_blk_next;
        rsp_ev_dirty_reg <= rsp_ev_dirty_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        free_next         = free_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        rsp_valid_next    = rsp_valid_reg;
        slot_next         = slot_reg;
        act_next          = act_reg;
        tag_next          = tag_reg;
        fslot_next        = fslot_reg;
        fdirty_next       = fdirty_reg;
        fupd_next         = fupd_reg;
        hit_next          = hit_reg;
        ffree_next        = ffree_reg;
        evict_next        = evict_reg;
        ev_tag_next       = ev_tag_reg;
        ev_dirty_next     = ev_dirty_reg;
        rsp_slot_next     = rsp_slot_reg;
        rsp_hit_next      = rsp_hit_reg;
        rsp_free_next     = rsp_free_reg;
        rsp_ev_next       = rsp_ev_reg;
        rsp_ev_blk_next   = rsp_ev_blk_reg;
        rsp_ev_dirty_next = rsp_ev_dirty_reg;

        tag_we    = 1'b0;
        tag_waddr = '0;
        tag_wdata = '0;
        tag_re    = 1'b0;
        tag_raddr = '0;
        flg_we    = 1'b0;
        flg_waddr = '0;
        flg_wdata = '0;
        flg_re    = 1'b0;
        flg_raddr = '0;
        nxt_we    = 1'b0;
        nxt_waddr = '0;
        nxt_wdata = '0;
        nxt_re    = 1'b0;
        nxt_raddr = '0;
        prv_we    = 1'b0;
        prv_waddr = '0;
        prv_wdata = '0;
        prv_re    = 1'b0;
        prv_raddr = '0;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    act_next      = req.action;
                    tag_next      = TAG_W'(req.block_number);
                    fslot_next    = req.flag_slot;
                    fdirty_next   = req.new_dirty;
                    fupd_next     = req.new_uptodate;
                    hit_next      = 1'b0;
                    ffree_next    = 1'b0;
                    evict_next    = 1'b0;
                    ev_tag_next   = '0;
                    ev_dirty_next = 1'b0;
                    slot_next     = '0;
                    if (req.action == ACT_FLAGS)
                    begin
                        state_next = ST_FLAG_RD;
                    end
                    else if (cache_empty)
                    begin
                        state_next = ST_FILL_FREE;
                    end
                    else
                    begin
                        tag_re     = 1'b1;
                        tag_raddr  = '0;
                        state_next = ST_SEARCH;
                    end
                end
            end

            ST_SEARCH:
            begin
                if (tag_match)
                begin
                    hit_next   = 1'b1;
                    flg_re     = 1'b1;
                    flg_raddr  = slot_reg;
                    nxt_re     = 1'b1;
                    nxt_raddr  = slot_reg;
                    prv_re     = 1'b1;
                    prv_raddr  = slot_reg;
                    state_next = ST_HIT_CHK;
                end
                else if (scan_last)
                begin
                    if (cache_full)
                    begin
                        tag_re     = 1'b1;
                        tag_raddr  = head_reg;
                        flg_re     = 1'b1;
                        flg_raddr  = head_reg;
                        nxt_re     = 1'b1;
                        nxt_raddr  = head_reg;
                        prv_re     = 1'b1;
                        prv_raddr  = head_reg;
                        slot_next  = head_reg;
                        evict_next = 1'b1;
                        state_next = ST_EVICT;
                    end
                    else
                    begin
                        state_next = ST_FILL_FREE;
                    end
                end
                else
                begin
                    tag_re    = 1'b1;
                    tag_raddr = slot_reg + SLOT_W'(1);
                    slot_next = slot_reg + SLOT_W'(1);
                end
            end

            ST_HIT_CHK:
            begin
                flg_we             = 1'b1;
                flg_waddr          = slot_reg;
                flg_wdata          = flg_rdata;
                flg_wdata.touched  = 1'b1;
                if (!flg_rdata.dirty && flg_rdata.uptodate && (slot_reg != tail_reg))
                begin
                    state_next = ST_UNLINK;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_FILL_FREE:
            begin
                tag_we     = 1'b1;
                tag_waddr  = free_slot;
                tag_wdata  = tag_reg;
                flg_we     = 1'b1;
                flg_waddr  = free_slot;
                flg_wdata  = '0;
                if (cache_empty)
                begin
                    head_next = free_slot;
                end
                else
                begin
                    nxt_we    = 1'b1;
                    nxt_waddr = tail_reg;
                    nxt_wdata = free_slot;
                    prv_we    = 1'b1;
                    prv_waddr = free_slot;
                    prv_wdata = tail_reg;
                end
                tail_next  = free_slot;
                free_next  = free_reg - CNT_W'(1);
                slot_next  = free_slot;
                ffree_next = 1'b1;
                state_next = ST_DONE;
            end

            ST_EVICT:
            begin
                ev_tag_next   = tag_rdata;
                ev_dirty_next = flg_rdata.dirty;
                tag_we        = 1'b1;
                tag_waddr     = slot_reg;
                tag_wdata     = tag_reg;
                flg_we        = 1'b1;
                flg_waddr     = slot_reg;
                flg_wdata     = '0;
                if (slot_reg != tail_reg)
                begin
                    state_next = ST_UNLINK;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_UNLINK:
            begin
                if (slot_reg == head_reg)
                begin
                    head_next = nxt_rdata;
                end
                else
                begin
                    nxt_we    = 1'b1;
                    nxt_waddr = prv_rdata;
                    nxt_wdata = nxt_rdata;
                    prv_we    = 1'b1;
                    prv_waddr = nxt_rdata;
                    prv_wdata = prv_rdata;
                end
                state_next = ST_APPEND;
            end

            ST_APPEND:
            begin
                nxt_we     = 1'b1;
                nxt_waddr  = tail_reg;
                nxt_wdata  = slot_reg;
                prv_we     = 1'b1;
                prv_waddr  = slot_reg;
                prv_wdata  = tail_reg;
                tail_next  = slot_reg;
                state_next = ST_DONE;
            end

            ST_FLAG_RD:
            begin
                flg_re     = fslot_ok;
                flg_raddr  = fslot_idx;
                state_next = ST_FLAG_WR;
            end

            ST_FLAG_WR:
            begin
                flg_we             = fslot_ok;
                flg_waddr          = fslot_idx;
                flg_wdata.touched  = flg_rdata.touched;
                flg_wdata.uptodate = fupd_reg;
                flg_wdata.dirty    = fdirty_reg;
                state_next         = ST_DONE;
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next    = 1'b1;
                    rsp_slot_next     = (act_reg == ACT_FLAGS) ? fslot_reg
                                                               : SLOT_FIELD_W'(slot_reg);
                    rsp_hit_next      = hit_reg;
                    rsp_free_next     = ffree_reg;
                    rsp_ev_next       = evict_reg;
                    rsp_ev_blk_next   = BLOCK_NUM_W'(ev_tag_reg);
                    rsp_ev_dirty_next = ev_dirty_reg;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/bbc_chk.sv
`timescale 1ns / 1ps

module bbc_chk
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            req_valid,
    input logic                            req_ready,
    input logic                            rsp_valid,
    input logic                            rsp_ready,
    input logic                            rsp_hit,
    input logic                            rsp_from_free,
    input logic                            rsp_evicted_valid,
    input logic [bbc_pkg::BLOCK_NUM_W-1:0] rsp_evicted_block,
    input logic                            rsp_evicted_dirty
);

    // one item in flight: ready drops right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
    else $error("ready stayed high after an accepted item");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> $onehot0({rsp_hit, rsp_from_free, rsp_evicted_valid}))
    else $error("more than one outcome flagged in a result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_evicted_valid) |-> (rsp_evicted_block == '0 && !rsp_evicted_dirty))
    else $error("eviction fields set without an eviction");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid)
    else $error("result dropped while stalled");

endmodule

bind block_buffer_cache_lru bbc_chk u_bbc_chk
(
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_hit           (rsp.hit),
    .rsp_from_free     (rsp.from_free),
    .rsp_evicted_valid (rsp.evicted_valid),
    .rsp_evicted_block (rsp.evicted_block),
    .rsp_evicted_dirty (rsp.evicted_dirty)
);
